// ----- rtl/core/tmse_pkg.sv -----
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types and constants of the Turing machine step engine: the tape
// geometry, the register reset values, the controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmse_pkg;

  localparam int unsigned TAPE_CELLS = 65536;
  localparam int unsigned TAPE_AW    = $clog2(TAPE_CELLS);

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned RULES   = 12;
  localparam int unsigned NEXT_W  = STATE_W * RULES;
  localparam int unsigned IN_DW   = 16;
  localparam int unsigned OUT_DW  = 56;

  localparam logic [RULES-1:0]  WRITE_RESET = 12'd437;
  localparam logic [RULES-1:0]  MOVE_RESET  = 12'd3725;
  localparam logic [NEXT_W-1:0] NEXT_RESET  = 36'd36741065369;

  // Machine states: 0 to 5 run, 6 and 7 mean halt.
  localparam logic [STATE_W-1:0] ST_A       = 3'd0;
  localparam logic [STATE_W-1:0] ST_LAST    = 3'd5;
  localparam logic [STATE_W-1:0] ST_HALT_LO = 3'd6;
  localparam logic [STATE_W-1:0] ST_HALT    = 3'd7;

  // Cell codes.
  localparam logic [1:0] CELL_BLANK = 2'd0;
  localparam logic [1:0] CELL_ZERO  = 2'd1;
  localparam logic [1:0] CELL_ONE   = 2'd2;

  // Request kinds.
  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WRITE_BITS = 2'd0;
  localparam logic [1:0] CFG_MOVE_BITS  = 2'd1;
  localparam logic [1:0] CFG_NEXT_STATE = 2'd2;

  typedef enum logic [2:0] {
    CTRL_CLEAR = 3'b001,
    CTRL_IDLE  = 3'b010,
    CTRL_EXEC  = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic clear_en;  // write one blank cell of the clearing pass
    logic issue;     // take the input item and start its tape read
    logic commit;    // finish the item and load the result register
  } tmse_cmd_t;

  typedef struct packed {
    logic clear_last;  // clearing pass is at its final cell
    logic out_busy;    // result register holds an item not yet taken
  } tmse_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tmse_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmse_ctrl
// Controller of the step engine: runs the tape clearing pass after reset,
// then accepts one item at a time and commits it once the tape read is
// back and the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tmse_ctrl
  import tmse_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire tmse_status_t status,
  output tmse_cmd_t         cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.clear_en = 1'b0;
    cmd.issue    = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      CTRL_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_nxt = CTRL_IDLE;
        end
      end
      CTRL_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.issue = 1'b1;
          state_nxt = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        // Hold the read data until the previous result has been taken.
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = CTRL_IDLE;
        end
      end
      default: begin
        state_nxt = CTRL_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTRL_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tmse_datapath.sv -----
// ----------------------------------------------------------------------------
// tmse_datapath
// Tape memory, head, machine state, step counter, transition table
// registers and the result register of the step engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tmse_datapath
  import tmse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tmse_cmd_t          cmd,
  output tmse_status_t            status,
  input  wire logic               in_tuser,
  input  wire logic [IN_DW-1:0]   in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_DW-1:0]       out_tdata,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [NEXT_W-1:0]  cfg_data
);

  logic [1:0] tape_mem [TAPE_CELLS];

  logic [RULES-1:0]   write_bits_r;
  logic [RULES-1:0]   move_bits_r;
  logic [NEXT_W-1:0]  next_states_r;

  logic [TAPE_AW-1:0] clr_cnt_r;
  logic [TAPE_AW-1:0] head_r, head_nxt;
  logic [STATE_W-1:0] mstate_r, mstate_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               req_r;
  logic               addr_ok_r;
  logic [1:0]         rdata_r;

  logic               out_valid_r;
  logic [OUT_DW-1:0]  out_data_r;

  logic               mem_we;
  logic [TAPE_AW-1:0] mem_waddr;
  logic [1:0]         mem_wdata;
  logic [TAPE_AW-1:0] mem_raddr;

  logic               is_halted;
  logic               sym;
  logic [3:0]         rule;
  logic               rule_right;
  logic [STATE_W-1:0] rule_next;
  logic [1:0]         code;
  logic [1:0]         cell_out;

  assign status.clear_last = (clr_cnt_r == TAPE_AW'(TAPE_CELLS - 1));
  assign status.out_busy   = out_valid_r && !out_tready;

  assign is_halted  = (mstate_r > ST_LAST);
  assign sym        = (rdata_r == CELL_ONE);
  // Rule index is two times the state plus the symbol read.
  assign rule       = {mstate_r, sym};
  assign code       = write_bits_r[rule] ? CELL_ONE : CELL_ZERO;
  assign rule_right = move_bits_r[rule];
  assign rule_next  = next_states_r[rule * 3 +: 3];

  always_comb begin
    head_nxt   = head_r;
    mstate_nxt = mstate_r;
    count_nxt  = count_r;
    cell_out   = rdata_r;
    if (req_r == REQ_READ) begin
      cell_out = addr_ok_r ? rdata_r : CELL_BLANK;
    end else if (is_halted) begin
      mstate_nxt = ST_HALT;
    end else begin
      cell_out   = code;
      count_nxt  = count_r + 1'b1;
      mstate_nxt = (rule_next >= ST_HALT_LO) ? ST_HALT : rule_next;
      // Moving off either end of the tape halts with the head in place.
      if (rule_right) begin
        if (head_r == TAPE_AW'(TAPE_CELLS - 1)) begin
          mstate_nxt = ST_HALT;
        end else begin
          head_nxt = head_r + 1'b1;
        end
      end else begin
        if (head_r == '0) begin
          mstate_nxt = ST_HALT;
        end else begin
          head_nxt = head_r - 1'b1;
        end
      end
    end
  end

  assign mem_we    = cmd.clear_en || (cmd.commit && (req_r == REQ_STEP) && !is_halted);
  assign mem_waddr = cmd.clear_en ? clr_cnt_r : head_r;
  assign mem_wdata = cmd.clear_en ? CELL_BLANK : code;
  assign mem_raddr = (in_tuser == REQ_READ) ? TAPE_AW'(in_tdata) : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.issue) begin
      rdata_r <= tape_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      req_r     <= in_tuser;
      addr_ok_r <= (32'(in_tdata) < 32'(TAPE_CELLS));
    end
    if (cmd.commit) begin
      out_data_r <= {2'b00, cell_out, count_nxt, (mstate_nxt == ST_HALT),
                     16'(head_nxt), mstate_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_bits_r  <= WRITE_RESET;
      move_bits_r   <= MOVE_RESET;
      next_states_r <= NEXT_RESET;
      clr_cnt_r     <= '0;
      head_r        <= TAPE_AW'(TAPE_CELLS / 2);
      mstate_r      <= ST_A;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WRITE_BITS: write_bits_r  <= cfg_data[RULES-1:0];
          CFG_MOVE_BITS:  move_bits_r   <= cfg_data[RULES-1:0];
          CFG_NEXT_STATE: next_states_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clear_en) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        mstate_r    <= mstate_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/turing_machine_step_engine.sv -----
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Two-symbol Turing machine with up to six states on a 65536-cell tape.
//
// Usage: each input item is a request. in_tuser is the request kind
// (0 runs one machine step, 1 reads the tape cell at in_tdata). Every item
// gives exactly one result item with the machine state, head position,
// halt flag, step count and a cell code after the item.
// The transition table is loaded through the cfg_ write channel (index 0
// write bits, 1 move-right bits, 2 next states); it is always ready, and
// is meant to be written only while no item is in flight.
// Flow: items are taken one at a time. An accepted item has its tape cell
// read into a register in the idle state; in the exec state it commits,
// writing a step's cell back and loading the result register.
// Reset: the table returns to its default, the head goes to cell 32768,
// the state to A and the count to zero. The tape is then cleared by a
// pass over the 65536 cells, one cell a cycle, while in_tready is low.
// Stalls: a waiting result sits in the output register; one more item is
// accepted and then held until the result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module turing_machine_step_engine
  import tmse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_DW-1:0]   in_tdata,   // [15:0] cell_addr
  input  wire logic               in_tuser,   // [0] req_type
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [2:0] machine_state, [18:3] head_position, [19] halted,
  // [51:20] step_count, [53:52] cell_value, [55:54] zero
  output logic [OUT_DW-1:0]       out_tdata,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [NEXT_W-1:0]  cfg_data
);

  tmse_cmd_t    cmd;
  tmse_status_t status;

  assign cfg_ready = 1'b1;

  tmse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tmse_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire

// ----- verif/turing_machine_step_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turing_machine_step_engine_test
// Self-checking bench for the Turing machine step engine. It drives step and
// read requests on the input stream and loads transition tables over the
// cfg_ channel. It keeps its own copy of the tape, head, state and step
// count, and checks every result field by field. The directed part covers
// reset values and table extremes. Random tables then run under three
// mixes of sender and receiver stalls. The run ends by halting the machine
// through a cause picked at random, then sends steps and reads to it.
// ----------------------------------------------------------------------------

module turing_machine_step_engine_test;
  import tmse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned BLOCK_ITEMS = 44;

  typedef enum int unsigned {
    HALT_BY_SIX,
    HALT_BY_SEVEN
  } halt_kind_t;

  typedef struct packed {
    logic [1:0]         cell_code;
    logic [COUNT_W-1:0] steps;
    logic               halted;
    logic [ADDR_W-1:0]  head;
    logic [STATE_W-1:0] state;
  } tm_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_DW-1:0]   in_tdata = '0;   // [15:0] cell_addr
  logic               in_tuser = 1'b0; // [0] req_type
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // [2:0] machine_state, [18:3] head_position, [19] halted,
  // [51:20] step_count, [53:52] cell_value, [55:54] zero
  logic [OUT_DW-1:0]  out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_WRITE_BITS;
  logic [NEXT_W-1:0]  cfg_data = '0;

  // Shadow of the machine.
  logic [1:0]         tape_model [TAPE_CELLS];
  logic [ADDR_W-1:0]  head_model = ADDR_W'(TAPE_CELLS / 2);
  logic [STATE_W-1:0] state_model = ST_A;
  logic [COUNT_W-1:0] steps_model = '0;
  logic [RULES-1:0]   write_model = WRITE_RESET;
  logic [RULES-1:0]   move_model = MOVE_RESET;
  logic [NEXT_W-1:0]  next_model = NEXT_RESET;

  tm_result_t  pending_results[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned steps_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned tables_loaded = 0;
  int unsigned cycle_count = 0;
  halt_kind_t  halt_how;

  turing_machine_step_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Works out the result of one request and updates the shadow machine.
  function automatic tm_result_t advance_machine(input logic kind,
                                                 input logic [ADDR_W-1:0] addr);
    tm_result_t         r;
    int unsigned        rule;
    logic [STATE_W-1:0] nxt;
    logic [1:0]         code;
    if (kind == REQ_READ) begin
      r.cell_code = tape_model[addr];
    end else if (state_model > ST_LAST) begin
      state_model = ST_HALT;
      r.cell_code = tape_model[head_model];
    end else begin
      rule = 2 * state_model + ((tape_model[head_model] == CELL_ONE) ? 1 : 0);
      code = write_model[rule] ? CELL_ONE : CELL_ZERO;
      nxt = next_model[3 * rule +: 3];
      tape_model[head_model] = code;
      if (nxt >= ST_HALT_LO)
        nxt = ST_HALT;
      // A move off either end of the tape halts and leaves the head in place.
      if (move_model[rule]) begin
        if (head_model == ADDR_W'(TAPE_CELLS - 1))
          nxt = ST_HALT;
        else
          head_model = head_model + 1'b1;
      end else begin
        if (head_model == '0)
          nxt = ST_HALT;
        else
          head_model = head_model - 1'b1;
      end
      state_model = nxt;
      steps_model = steps_model + 1'b1;
      r.cell_code = code;
    end
    r.state = state_model;
    r.head = head_model;
    r.halted = (state_model == ST_HALT);
    r.steps = steps_model;
    return r;
  endfunction

  always @(posedge clk) begin
    tm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("Result item arrived with nothing expected: %h", out_tdata);
        error_count <= error_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.state) begin
          $error("machine_state: expected %0d, got %0d", want.state, out_tdata[2:0]);
          error_count <= error_count + 1;
        end
        if (out_tdata[18:3] !== want.head) begin
          $error("head_position: expected %0d, got %0d", want.head, out_tdata[18:3]);
          error_count <= error_count + 1;
        end
        if (out_tdata[19] !== want.halted) begin
          $error("halted: expected %0d, got %0d", want.halted, out_tdata[19]);
          error_count <= error_count + 1;
        end
        if (out_tdata[51:20] !== want.steps) begin
          $error("step_count: expected %0d, got %0d", want.steps, out_tdata[51:20]);
          error_count <= error_count + 1;
        end
        if (out_tdata[53:52] !== want.cell_code) begin
          $error("cell_value: expected %0d, got %0d", want.cell_code, out_tdata[53:52]);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Sends one request. Valid stays high after acceptance; the next caller
  // either drives a new item or lowers it.
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= addr;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(advance_machine(kind, addr));
    if (kind == REQ_READ)
      reads_sent++;
    else
      steps_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [NEXT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WRITE_BITS: write_model = value[RULES-1:0];
      CFG_MOVE_BITS:  move_model = value[RULES-1:0];
      CFG_NEXT_STATE: next_model = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(input logic [RULES-1:0] wbits, input logic [RULES-1:0] mbits,
                            input logic [NEXT_W-1:0] nexts);
    wait_for_results();
    write_register(CFG_WRITE_BITS, NEXT_W'(wbits));
    write_register(CFG_MOVE_BITS, NEXT_W'(mbits));
    write_register(CFG_NEXT_STATE, nexts);
    tables_loaded++;
  endtask

  function automatic logic [NEXT_W-1:0] same_next(input logic [STATE_W-1:0] s);
    return {RULES{s}};
  endfunction

  // Next states that never halt, so the machine keeps running.
  function automatic logic [NEXT_W-1:0] running_next();
    logic [NEXT_W-1:0] n;
    for (int i = 0; i < RULES; i++)
      n[3 * i +: 3] = STATE_W'($urandom_range(ST_LAST));
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] near_head();
    return head_model + ADDR_W'($urandom_range(16)) - ADDR_W'(8);
  endfunction

  task automatic check_after_reset();
    send_request(REQ_READ, '0);
    send_request(REQ_READ, '1);
    send_request(REQ_READ, ADDR_W'(TAPE_CELLS / 2));
    send_request(REQ_READ, ADDR_W'($urandom));
    // A few steps of the default table; it runs far longer than this.
    repeat (6) send_request(REQ_STEP, ADDR_W'($urandom));
    send_request(REQ_READ, head_model);
    send_request(REQ_READ, ADDR_W'(TAPE_CELLS / 2));
  endtask

  task automatic check_table_extremes();
    // All-halt table loaded but only read against, then replaced.
    load_table('1, '0, '1);
    send_request(REQ_READ, head_model);
    load_table('1, '0, same_next(ST_A));
    repeat (3) send_request(REQ_STEP, '1);
    send_request(REQ_READ, head_model + 1'b1);
    load_table('0, '1, same_next(ST_LAST));
    repeat (3) send_request(REQ_STEP, '0);
    send_request(REQ_READ, head_model - 1'b1);
  endtask

  task automatic run_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                    input int unsigned items);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % BLOCK_ITEMS == 0)
        load_table(RULES'($urandom), RULES'($urandom), running_next());
      else if ($urandom_range(49) == 0)
        wait_for_results();
      if ($urandom_range(9) < 7)
        send_request(REQ_STEP, ADDR_W'($urandom));
      else if ($urandom_range(4) < 3)
        send_request(REQ_READ, near_head());
      else
        send_request(REQ_READ, ADDR_W'($urandom_range(TAPE_CELLS - 1)));
    end
    wait_for_results();
  endtask

  task automatic check_halting();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    halt_how = halt_kind_t'($urandom_range(HALT_BY_SEVEN));
    case (halt_how)
      HALT_BY_SIX: load_table(RULES'($urandom), RULES'($urandom), same_next(ST_HALT_LO));
      default:     load_table(RULES'($urandom), RULES'($urandom), same_next(ST_HALT));
    endcase
    while (state_model != ST_HALT)
      send_request(REQ_STEP, ADDR_W'($urandom));
    repeat (4) send_request(REQ_STEP, ADDR_W'($urandom));
    repeat (4) send_request(REQ_READ, near_head());
    // A running table must not bring the machine back.
    load_table(RULES'($urandom), RULES'($urandom), running_next());
    repeat (3) send_request(REQ_STEP, ADDR_W'($urandom));
    send_request(REQ_READ, head_model);
    wait_for_results();
  endtask

  initial begin
    foreach (tape_model[i])
      tape_model[i] = CELL_BLANK;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_after_reset();
    check_table_extremes();
    run_random_traffic(27, 65, 133);
    run_random_traffic(65, 27, 133);
    run_random_traffic(0, 0, 134);
    check_halting();

    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      error_count++;
    end
    $display("Ran %0d steps and %0d cell reads over %0d transition tables.",
             steps_sent, reads_sent, tables_loaded);
    $display("Checked %0d result items; the machine halted by %s.",
             results_seen, halt_how.name());
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- turing_machine_step_engine.f -----
rtl/core/tmse_pkg.sv
rtl/core/tmse_ctrl.sv
rtl/core/tmse_datapath.sv
rtl/core/turing_machine_step_engine.sv
verif/turing_machine_step_engine_test.sv
